// File: sv/spiq_pkg.sv
package spiq_pkg;

   localparam int ENTRY_W = 42;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [2:0] PRIO_MIN = 3'd1;
   localparam logic [2:0] PRIO_MAX = 3'd5;

   typedef struct packed {
      logic [2:0]  prio;
      logic [6:0]  age;
      logic [31:0] tag;
   } entry_type;

   typedef struct packed {
      logic load;
      logic rd_head;
      logic shift;
      logic place;
      logic pop;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic at_head;
      logic shift_go;
      logic out_busy;
   } dp_sts_type;

endpackage

// File: sv/stable_priority_insert_queue.sv
// Priority queue of up to DEPTH-1 entries, kept in order of urgency (1 most
// urgent, 5 least); entries of one level leave in arrival order. Each request
// word carries a command in req_tuser: insert places the entry behind all
// stored entries of equal or higher urgency, remove returns the head entry.
// Every request yields exactly one response word whose tuser gives done,
// full or empty; refused commands leave the queue untouched. Entries live in
// a single-port-read, single-port-write RAM, and insert moves the less urgent
// entries (at most DEPTH-2) back one slot per cycle from the tail. Each
// command holds the input until its response word is loaded into the output
// register, which waits for rsp_tready to take the previous response word. A
// new request is taken while the previous response still waits in the output
// register.
module stable_priority_insert_queue
   import spiq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] entry_priority, [9:3] entry_age, [41:10] entry_tag, [47:42] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] command
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [2:0] out_priority, [9:3] out_age, [41:10] out_tag, [45:42] fill_count,
   // [47:46] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   entry_type   rsp_entry;
   logic [3:0]  rsp_fill;

   spiq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_command(req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   spiq_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_command (req_tuser),
      .req_priority(req_tdata[2:0]),
      .req_age     (req_tdata[9:3]),
      .req_tag     (req_tdata[41:10]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_entry   (rsp_entry),
      .rsp_fill    (rsp_fill)
   );

   assign rsp_tdata = {2'b00, rsp_fill, rsp_entry.tag, rsp_entry.age, rsp_entry.prio};

endmodule

// File: sv/spiq_ram.sv
module spiq_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/spiq_ctrl.sv
module spiq_ctrl
   import spiq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_command,
   output logic        req_tready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INS  = 2'd1;
   localparam logic [1:0] S_REM  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.rd_head = (req_command == CMD_REMOVE);
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_command == CMD_INSERT) begin
                  state_in = sts.full ? S_FIN : S_INS;
               end else begin
                  state_in = sts.empty ? S_FIN : S_REM;
               end
            end
         end
         S_INS: begin
            if (sts.at_head || !sts.shift_go) begin
               cmd.place = 1'b1;
               state_in  = S_FIN;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         S_REM: begin
            cmd.pop  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/spiq_dpath.sv
module spiq_dpath
   import spiq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output dp_sts_type  sts,
   input  logic        req_command,
   input  logic [2:0]  req_priority,
   input  logic [6:0]  req_age,
   input  logic [31:0] req_tag,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_status,
   output entry_type   rsp_entry,
   output logic [3:0]  rsp_fill
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      idx_next = (i == LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      idx_prev = (i == '0) ? LAST : i - 1'b1;
   endfunction

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   entry_type        item_ff, item_in;
   entry_type        res_entry_ff, res_entry_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   entry_type        rsp_entry_ff;
   logic [3:0]       rsp_fill_ff;

   logic [2:0]         clamp_prio;
   logic [IDX_W:0]     fill_diff;
   logic [IDX_W+4:0]   fill_wide;
   logic               mem_we;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type          rd_entry;

   spiq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(pos_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   always_comb begin
      if (req_priority == 3'd0) begin
         clamp_prio = PRIO_MIN;
      end else if (req_priority > PRIO_MAX) begin
         clamp_prio = PRIO_MAX;
      end else begin
         clamp_prio = req_priority;
      end
   end

   always_comb begin
      if (tail_ff >= head_ff) begin
         fill_diff = {1'b0, tail_ff} - {1'b0, head_ff};
      end else begin
         fill_diff = {1'b0, tail_ff} + (IDX_W+1)'(DEPTH) - {1'b0, head_ff};
      end
      fill_wide = {4'b0, fill_diff};
   end

   assign sts.full     = (idx_next(tail_ff) == head_ff);
   assign sts.empty    = (head_ff == tail_ff);
   assign sts.at_head  = (pos_ff == head_ff);
   assign sts.shift_go = (rd_entry.prio > item_ff.prio);
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

   assign mem_we  = cmd.shift || cmd.place;
   assign wr_data = cmd.shift ? rd_raw : ENTRY_W'(item_ff);
   assign rd_addr = cmd.rd_head ? head_ff : idx_prev(pos_in);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      pos_in        = pos_ff;
      item_in       = item_ff;
      res_entry_in  = res_entry_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (cmd.load) begin
         pos_in       = tail_ff;
         item_in      = '{prio: clamp_prio, age: req_age, tag: req_tag};
         res_entry_in = '0;
         if (req_command == CMD_INSERT) begin
            res_status_in = sts.full ? STATUS_FULL : STATUS_DONE;
         end else begin
            res_status_in = sts.empty ? STATUS_EMPTY : STATUS_DONE;
         end
      end
      if (cmd.shift) begin
         pos_in = idx_prev(pos_ff);
      end
      if (cmd.place) begin
         tail_in = idx_next(tail_ff);
      end
      if (cmd.pop) begin
         res_entry_in = rd_entry;
         head_in      = idx_next(head_ff);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      item_ff       <= item_in;
      res_entry_ff  <= res_entry_in;
      res_status_ff <= res_status_in;
      if (cmd.finish) begin
         rsp_status_ff <= res_status_ff;
         rsp_entry_ff  <= res_entry_ff;
         rsp_fill_ff   <= fill_wide[3:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_fill   = rsp_fill_ff;

endmodule

// File: sv/spiq_checker.sv
module spiq_checker
   import spiq_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_DONE |-> rsp_tdata[41:0] == 42'd0)
      else $error("refused command returned an entry");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tdata[45:42] == 4'd0)
      else $error("empty refusal with nonzero fill count");

   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'd0 |-> rsp_tdata[2:0] <= PRIO_MAX)
      else $error("removed entry priority out of range");

endmodule

bind stable_priority_insert_queue spiq_checker u_spiq_checker (.*);

// File: tb/sv/spiq_tb_pkg.sv
package spiq_tb_pkg;

   import spiq_pkg::*;

   localparam int QUEUE_DEPTH = 16;

   typedef struct {
      logic [1:0] status;
      entry_type  removed;
      logic [3:0] fill;
   } queue_rsp_type;

   class queue_scoreboard;

      entry_type     slots[QUEUE_DEPTH];
      logic [3:0]    head;
      logic [3:0]    tail;
      queue_rsp_type expected_rsps[$];
      int            errors;
      int            inserts;
      int            removes;
      int            full_refusals;
      int            empty_refusals;
      int            peak_fill;
      int            checked;

      function new();
         head = '0;
         tail = '0;
         errors = 0;
         inserts = 0;
         removes = 0;
         full_refusals = 0;
         empty_refusals = 0;
         peak_fill = 0;
         checked = 0;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function void note_request(input logic cmd, input logic [REQ_DATA_W-1:0] data);
         entry_type     item;
         queue_rsp_type rsp;
         logic [3:0]    pos;
         logic [3:0]    j;
         item.prio = data[2:0];
         item.age = data[9:3];
         item.tag = data[41:10];
         rsp.status = STATUS_DONE;
         rsp.removed = '0;
         if (cmd == CMD_INSERT) begin
            if (tail + 4'd1 == head) begin
               rsp.status = STATUS_FULL;
               full_refusals++;
            end else begin
               if (item.prio < PRIO_MIN) item.prio = PRIO_MIN;
               if (item.prio > PRIO_MAX) item.prio = PRIO_MAX;
               pos = head;
               while (pos != tail && slots[pos].prio <= item.prio) pos++;
               j = tail;
               while (j != pos) begin
                  slots[j] = slots[j - 4'd1];
                  j--;
               end
               slots[pos] = item;
               tail++;
               inserts++;
            end
         end else begin
            if (head == tail) begin
               rsp.status = STATUS_EMPTY;
               empty_refusals++;
            end else begin
               rsp.removed = slots[head];
               head++;
               removes++;
            end
         end
         rsp.fill = tail - head;
         if (int'(rsp.fill) > peak_fill) peak_fill = int'(rsp.fill);
         expected_rsps.push_back(rsp);
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(input logic [RSP_DATA_W-1:0] data,
                                   input logic [1:0] status);
         queue_rsp_type want;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response word: status %0d data %h", $time, status, data);
            errors++;
            return;
         end
         want = expected_rsps.pop_front();
         checked++;
         compare_field("status", 32'(want.status), 32'(status));
         compare_field("out_priority", 32'(want.removed.prio), 32'(data[2:0]));
         compare_field("out_age", 32'(want.removed.age), 32'(data[9:3]));
         compare_field("out_tag", want.removed.tag, data[41:10]);
         compare_field("fill_count", 32'(want.fill), 32'(data[45:42]));
      endfunction

   endclass

endpackage

// File: tb/sv/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import spiq_pkg::*;
   import spiq_tb_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 32;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = CMD_INSERT;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   int send_hold_pct = 0;
   int rsp_hold_pct = 0;
   int idle_cycles = 0;

   queue_scoreboard sb = new();

   stable_priority_insert_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_word(input logic cmd, input logic [REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < send_hold_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, data);
   endtask

   task automatic send_insert(input logic [2:0] prio, input logic [6:0] age,
                              input logic [31:0] tag);
      send_word(CMD_INSERT, {6'd0, tag, age, prio});
   endtask

   task automatic send_remove();
      send_word(CMD_REMOVE, {6'd0, $urandom(), 10'($urandom())});
   endtask

   task automatic send_random_word(input int insert_pct);
      logic [2:0] prio;
      if ($urandom_range(99) < insert_pct) begin
         if ($urandom_range(9) == 0) prio = 3'($urandom_range(7));
         else prio = 3'($urandom_range(5, 1));
         send_insert(prio, 7'($urandom_range(127)), $urandom());
      end else begin
         send_remove();
      end
   endtask

   // drift the fill level between full and empty in runs of random length
   task automatic run_phase(input int words);
      int insert_pct;
      int run_left;
      run_left = 0;
      insert_pct = 50;
      for (int n = 0; n < words; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(60, 15);
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 50;
               default: insert_pct = 20;
            endcase
         end
         run_left--;
         send_random_word(insert_pct);
      end
   endtask

   task automatic run_directed();
      send_remove();
      send_insert(3'd0, 7'd0, 32'h0000_0000);
      send_insert(3'd7, 7'd127, 32'hFFFF_FFFF);
      send_insert(3'd1, 7'd1, 32'h0000_0001);
      send_insert(3'd2, 7'd64, 32'h8000_0000);
      send_insert(3'd3, 7'd63, 32'h7FFF_FFFF);
      send_insert(3'd4, 7'd85, 32'hA5A5_A5A5);
      send_insert(3'd5, 7'd42, 32'h5A5A_5A5A);
      send_insert(3'd6, 7'd126, 32'hFFFF_FFFE);
      send_insert(3'd5, 7'd10, 32'h0000_0010);
      send_insert(3'd4, 7'd11, 32'h0000_0011);
      send_insert(3'd3, 7'd12, 32'h0000_0012);
      send_insert(3'd2, 7'd13, 32'h0000_0013);
      send_insert(3'd1, 7'd14, 32'h0000_0014);
      send_insert(3'd3, 7'd15, 32'h0000_0015);
      send_insert(3'd5, 7'd16, 32'h0000_0016);
      send_insert(3'd1, 7'd17, 32'h0000_0017);
      repeat (3) send_remove();
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(99) >= rsp_hold_pct);
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, sb.pending());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_hold_pct = 19;
      rsp_hold_pct = 47;
      run_directed();
      run_phase(410);
      send_hold_pct = 47;
      rsp_hold_pct = 19;
      run_phase(430);
      send_hold_pct = 0;
      rsp_hold_pct = 0;
      run_phase(430);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Queue saw %0d inserts, %0d removes, %0d full and %0d empty refusals,",
               sb.inserts, sb.removes, sb.full_refusals, sb.empty_refusals);
      $display("peak fill %0d; %0d responses checked, %0d mismatches.",
               sb.peak_fill, sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
